### hw/rtl/date_time_set_editor_unit_defines.svh
// Assertion macros shared by the date and time editor RTL
`ifndef DATE_TIME_SET_EDITOR_UNIT_DEFINES_SVH
`define DATE_TIME_SET_EDITOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTSE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dtse assertion failed");

// next-cycle implication, disabled during reset
`define DTSE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dtse assertion failed");

`endif

### hw/rtl/dtse_pkg.sv
// Types, constants and field helpers for the date and time editor
`timescale 1ns / 1ps

package dtse_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_INC  = 2'd1,
        MODE_DEC  = 2'd2,
        MODE_SET  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_YEAR    = 3'd1,
        POS_MONTH   = 3'd2,
        POS_DAY     = 3'd3,
        POS_HOUR    = 3'd4,
        POS_MINUTE  = 3'd5,
        POS_WEEKDAY = 3'd6
    } pos_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } fields_t;

    typedef struct packed {
        fields_t fields;
        pos_t    pos;
    } state_t;

    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [6:0] MONTH_MIN   = 7'd1;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] DAY_MIN     = 7'd1;
    localparam logic [6:0] HOUR_MAX    = 7'd23;
    localparam logic [6:0] MINUTE_MAX  = 7'd59;
    localparam logic [6:0] WEEKDAY_MIN = 7'd1;
    localparam logic [6:0] WEEKDAY_MAX = 7'd7;
    localparam logic [6:0] FIELD_ZERO  = 7'd0;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    // leap rule: any year divisible by 4; unknown months count as 31 days
    function automatic logic [6:0] month_days(logic [3:0] month, logic [6:0] year);
        logic [6:0] days;
        if (month == MONTH_FEB) begin
            days = (year[1:0] == 2'b00) ? 7'd29 : 7'd28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            days = 7'd30;
        end else begin
            days = 7'd31;
        end
        return days;
    endfunction

    // INC/DEC wrap, SET clamps to hi; load leaves the value alone
    function automatic logic [6:0] field_step(mode_t mode, logic [6:0] v,
                                              logic [6:0] lo, logic [6:0] hi);
        logic [7:0] v_inc;
        logic [6:0] v_dec;
        logic [6:0] res;
        v_inc = {1'b0, v} + 8'd1;
        v_dec = v - 7'd1;
        res   = v;
        unique case (mode)
            MODE_INC: begin
                res = (v_inc > {1'b0, hi}) ? lo : v_inc[6:0];
            end
            MODE_DEC: begin
                res = (v == FIELD_ZERO || v_dec < lo) ? hi : v_dec;
            end
            MODE_SET: begin
                res = (v > hi) ? hi : v;
            end
            MODE_LOAD: begin
                res = v;
            end
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/dtse_step.sv
// Next-state logic of the editor for one event
`timescale 1ns / 1ps

module dtse_step (
    input  dtse_pkg::state_t  cur,
    input  dtse_pkg::mode_t   mode,
    input  dtse_pkg::fields_t load,
    output dtse_pkg::state_t  nxt,
    output logic              commit
);

    logic [6:0] fval;
    logic [6:0] lo;
    logic [6:0] hi;
    logic [6:0] fnew;

    // select the field under edit and its limits
    always_comb begin
        fval = dtse_pkg::FIELD_ZERO;
        lo   = dtse_pkg::FIELD_ZERO;
        hi   = dtse_pkg::FIELD_ZERO;
        unique case (cur.pos)
            dtse_pkg::POS_YEAR: begin
                fval = cur.fields.year;
                hi   = dtse_pkg::YEAR_MAX;
            end
            dtse_pkg::POS_MONTH: begin
                fval = {3'd0, cur.fields.month};
                lo   = dtse_pkg::MONTH_MIN;
                hi   = dtse_pkg::MONTH_MAX;
            end
            dtse_pkg::POS_DAY: begin
                fval = {2'd0, cur.fields.day};
                lo   = dtse_pkg::DAY_MIN;
                hi   = dtse_pkg::month_days(cur.fields.month, cur.fields.year);
            end
            dtse_pkg::POS_HOUR: begin
                fval = {2'd0, cur.fields.hour};
                hi   = dtse_pkg::HOUR_MAX;
            end
            dtse_pkg::POS_MINUTE: begin
                fval = {1'd0, cur.fields.minute};
                hi   = dtse_pkg::MINUTE_MAX;
            end
            dtse_pkg::POS_WEEKDAY: begin
                fval = {4'd0, cur.fields.weekday};
                lo   = dtse_pkg::WEEKDAY_MIN;
                hi   = dtse_pkg::WEEKDAY_MAX;
            end
            default: begin
                fval = dtse_pkg::FIELD_ZERO;
            end
        endcase
    end

    assign fnew = dtse_pkg::field_step(mode, fval, lo, hi);

    always_comb begin
        nxt    = cur;
        commit = 1'b0;
        if (cur.pos == dtse_pkg::POS_IDLE) begin
            if (mode == dtse_pkg::MODE_LOAD) begin
                nxt.fields = load;
            end else if (mode == dtse_pkg::MODE_SET) begin
                nxt.pos           = dtse_pkg::POS_YEAR;
                nxt.fields.second = 6'd0;
            end
        end else begin
            unique case (cur.pos)
                dtse_pkg::POS_YEAR:    nxt.fields.year    = fnew;
                dtse_pkg::POS_MONTH:   nxt.fields.month   = fnew[3:0];
                dtse_pkg::POS_DAY:     nxt.fields.day     = fnew[4:0];
                dtse_pkg::POS_HOUR:    nxt.fields.hour    = fnew[4:0];
                dtse_pkg::POS_MINUTE:  nxt.fields.minute  = fnew[5:0];
                dtse_pkg::POS_WEEKDAY: nxt.fields.weekday = fnew[2:0];
                default:               nxt.pos            = dtse_pkg::POS_IDLE;
            endcase
            if (mode == dtse_pkg::MODE_SET) begin
                unique case (cur.pos)
                    dtse_pkg::POS_YEAR:   nxt.pos = dtse_pkg::POS_MONTH;
                    dtse_pkg::POS_MONTH:  nxt.pos = dtse_pkg::POS_DAY;
                    dtse_pkg::POS_DAY:    nxt.pos = dtse_pkg::POS_HOUR;
                    dtse_pkg::POS_HOUR:   nxt.pos = dtse_pkg::POS_MINUTE;
                    dtse_pkg::POS_MINUTE: nxt.pos = dtse_pkg::POS_WEEKDAY;
                    dtse_pkg::POS_WEEKDAY: begin
                        nxt.pos           = dtse_pkg::POS_IDLE;
                        nxt.fields.second = 6'd0;
                        commit            = 1'b1;
                    end
                    default: nxt.pos = dtse_pkg::POS_IDLE;
                endcase
            end
        end
    end

endmodule

### hw/rtl/date_time_set_editor_unit.sv
// Top level of the button-driven date and time editor
`timescale 1ns / 1ps
`include "date_time_set_editor_unit_defines.svh"

// Takes one event item per clock: a load of the clock's date and time or an
// INC, DEC or SET press, given by s_tuser. Each item updates the editor
// state in the cycle it is accepted and yields one result item, the state
// after the event plus a commit flag, from a single output register in the next
// cycle. Throughput is one item per cycle; s_tready drops only while
// that output register is full and m_tready is low.
module date_time_set_editor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[6:0] month[10:7] day[15:11] hour[20:16] minute[26:21]
    // second[32:27] weekday[35:33], zero pad[39:36]
    input  logic [39:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // edit_field[2:0] year_out[9:3] month_out[13:10] day_out[18:14]
    // hour_out[23:19] minute_out[29:24] second_out[35:30] weekday_out[38:36]
    // commit[39]
    output logic [39:0] m_tdata
);

    dtse_pkg::state_t  state_reg;
    dtse_pkg::state_t  state_next;
    dtse_pkg::fields_t load;
    dtse_pkg::mode_t   mode;
    logic              commit;
    logic              in_fire;
    logic              m_tvalid_reg;
    logic [39:0]       m_data_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign mode         = dtse_pkg::mode_t'(s_tuser);
    assign load.year    = s_tdata[6:0];
    assign load.month   = s_tdata[10:7];
    assign load.day     = s_tdata[15:11];
    assign load.hour    = s_tdata[20:16];
    assign load.minute  = s_tdata[26:21];
    assign load.second  = s_tdata[32:27];
    assign load.weekday = s_tdata[35:33];

    dtse_step u_step (
        .cur    (state_reg),
        .mode   (mode),
        .load   (load),
        .nxt    (state_next),
        .commit (commit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= {commit,
                           state_next.fields.weekday,
                           state_next.fields.second,
                           state_next.fields.minute,
                           state_next.fields.hour,
                           state_next.fields.day,
                           state_next.fields.month,
                           state_next.fields.year,
                           state_next.pos};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // a pending result always mirrors the current state
    `DTSE_ASSERT_IMP(a_out_mirrors_state, aclk, aresetn, m_tvalid_reg,
        (m_data_reg[38:0] == {state_reg.fields, state_reg.pos}))
    // commit only comes with the editor back at idle and seconds cleared
    `DTSE_ASSERT_IMP(a_commit_idle, aclk, aresetn, m_tvalid_reg && m_data_reg[39],
        m_data_reg[2:0] == dtse_pkg::POS_IDLE && m_data_reg[35:30] == 6'd0)
    // SET while idle opens the year field with seconds zeroed
    `DTSE_ASSERT_NXT(a_set_starts, aclk, aresetn,
        in_fire && state_reg.pos == dtse_pkg::POS_IDLE && mode == dtse_pkg::MODE_SET,
        state_reg.pos == dtse_pkg::POS_YEAR && state_reg.fields.second == 6'd0)
    // a load during editing leaves the stored date and time alone
    `DTSE_ASSERT_NXT(a_load_ignored, aclk, aresetn,
        in_fire && state_reg.pos != dtse_pkg::POS_IDLE && mode == dtse_pkg::MODE_LOAD,
        $stable(state_reg))

endmodule

### dv/dtse_checker.sv
`timescale 1ns / 1ps
// Checker for the date and time editor: predicts each result item and compares it

module dtse_checker
    import dtse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatch_count,
    output int          pending_count
);

    // same bit layout as m_tdata
    typedef struct packed {
        logic    commit;
        fields_t dt;
        pos_t    field;
    } editor_view_t;

    pos_t         edit_pos;
    fields_t      dt_now;
    editor_view_t expected_q[$];

    function automatic int field_value(pos_t p);
        int v;
        case (p)
            POS_YEAR:    v = int'(dt_now.year);
            POS_MONTH:   v = int'(dt_now.month);
            POS_DAY:     v = int'(dt_now.day);
            POS_HOUR:    v = int'(dt_now.hour);
            POS_MINUTE:  v = int'(dt_now.minute);
            POS_WEEKDAY: v = int'(dt_now.weekday);
            default:     v = 0;
        endcase
        return v;
    endfunction

    function automatic int field_lo(pos_t p);
        int lo;
        case (p)
            POS_MONTH:   lo = int'(MONTH_MIN);
            POS_DAY:     lo = int'(DAY_MIN);
            POS_WEEKDAY: lo = int'(WEEKDAY_MIN);
            default:     lo = int'(FIELD_ZERO);
        endcase
        return lo;
    endfunction

    function automatic int field_hi(pos_t p);
        int hi;
        case (p)
            POS_YEAR:    hi = int'(YEAR_MAX);
            POS_MONTH:   hi = int'(MONTH_MAX);
            POS_DAY: begin
                if (dt_now.month == MONTH_FEB) begin
                    hi = (dt_now.year[1:0] == 2'b00) ? 29 : 28;
                end else if (dt_now.month == MONTH_APR || dt_now.month == MONTH_JUN ||
                             dt_now.month == MONTH_SEP || dt_now.month == MONTH_NOV) begin
                    hi = 30;
                end else begin
                    hi = 31;
                end
            end
            POS_HOUR:    hi = int'(HOUR_MAX);
            POS_MINUTE:  hi = int'(MINUTE_MAX);
            POS_WEEKDAY: hi = int'(WEEKDAY_MAX);
            default:     hi = int'(FIELD_ZERO);
        endcase
        return hi;
    endfunction

    task automatic put_field(pos_t p, int v);
        case (p)
            POS_YEAR:    dt_now.year    = v[6:0];
            POS_MONTH:   dt_now.month   = v[3:0];
            POS_DAY:     dt_now.day     = v[4:0];
            POS_HOUR:    dt_now.hour    = v[4:0];
            POS_MINUTE:  dt_now.minute  = v[5:0];
            POS_WEEKDAY: dt_now.weekday = v[2:0];
            default: ;
        endcase
    endtask

    task automatic edit_event(input mode_t m, input fields_t load, output editor_view_t res);
        int v;
        int lo;
        int hi;
        res.commit = 1'b0;
        if (edit_pos == POS_IDLE) begin
            if (m == MODE_LOAD) begin
                dt_now = load;
            end else if (m == MODE_SET) begin
                edit_pos      = POS_YEAR;
                dt_now.second = '0;
            end
        end else begin
            v  = field_value(edit_pos);
            lo = field_lo(edit_pos);
            hi = field_hi(edit_pos);
            case (m)
                MODE_INC: put_field(edit_pos, (v + 1 > hi) ? lo : v + 1);
                MODE_DEC: put_field(edit_pos, (v == 0 || v - 1 < lo) ? hi : v - 1);
                MODE_SET: begin
                    if (v > hi) put_field(edit_pos, hi);
                    if (edit_pos == POS_WEEKDAY) begin
                        edit_pos      = POS_IDLE;
                        dt_now.second = '0;
                        res.commit    = 1'b1;
                    end else begin
                        edit_pos = pos_t'(edit_pos + 3'd1);
                    end
                end
                default: ;
            endcase
        end
        res.field = edit_pos;
        res.dt    = dt_now;
    endtask

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        editor_view_t got;
        editor_view_t want;
        if (!aresetn) begin
            edit_pos       = POS_IDLE;
            dt_now         = '0;
            mismatch_count = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result item %h with none expected", m_tdata));
                end else begin
                    want = expected_q.pop_front();
                    if (got.field !== want.field)
                        report_mismatch($sformatf("edit_field got %0d want %0d",
                                                  got.field, want.field));
                    if (got.dt.year !== want.dt.year)
                        report_mismatch($sformatf("year_out got %0d want %0d",
                                                  got.dt.year, want.dt.year));
                    if (got.dt.month !== want.dt.month)
                        report_mismatch($sformatf("month_out got %0d want %0d",
                                                  got.dt.month, want.dt.month));
                    if (got.dt.day !== want.dt.day)
                        report_mismatch($sformatf("day_out got %0d want %0d",
                                                  got.dt.day, want.dt.day));
                    if (got.dt.hour !== want.dt.hour)
                        report_mismatch($sformatf("hour_out got %0d want %0d",
                                                  got.dt.hour, want.dt.hour));
                    if (got.dt.minute !== want.dt.minute)
                        report_mismatch($sformatf("minute_out got %0d want %0d",
                                                  got.dt.minute, want.dt.minute));
                    if (got.dt.second !== want.dt.second)
                        report_mismatch($sformatf("second_out got %0d want %0d",
                                                  got.dt.second, want.dt.second));
                    if (got.dt.weekday !== want.dt.weekday)
                        report_mismatch($sformatf("weekday_out got %0d want %0d",
                                                  got.dt.weekday, want.dt.weekday));
                    if (got.commit !== want.commit)
                        report_mismatch($sformatf("commit got %0d want %0d",
                                                  got.commit, want.commit));
                end
            end
            if (s_tvalid && s_tready) begin
                edit_event(mode_t'(s_tuser), s_tdata[35:0], want);
                expected_q.push_back(want);
            end
        end
        pending_count = expected_q.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the date and time editor: stimulus, stalls, watchdog and verdict

module tb_top;
    import dtse_pkg::*;

    localparam int N_ITEMS     = 900;
    localparam int STALL_LIMIT = 1000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;

    int          mismatch_count;
    int          pending_count;
    int          idle_cycles = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    logic [31:0] tick_count  = '0;

    always #10 aclk = ~aclk;

    date_time_set_editor_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dtse_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // stall style follows bits [8:7] of tick_count
    always @(posedge aclk) begin
        tick_count <= tick_count + 32'd1;
        case (tick_count[8:7])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (tick_count[3:0] >= 4'd10);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input mode_t m, input fields_t f);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, f};
        s_tuser  <= m;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // mostly in-range dates, Feb favored; sometimes raw bits
    function automatic fields_t random_date();
        fields_t     f;
        logic [63:0] bits;
        if ($urandom_range(0, 4) == 0) begin
            bits = {$urandom, $urandom};
            f    = bits[35:0];
        end else begin
            f.year    = 7'($urandom_range(0, 99));
            f.month   = ($urandom_range(0, 2) == 0) ? MONTH_FEB : 4'($urandom_range(1, 12));
            f.day     = 5'($urandom_range(1, 31));
            f.hour    = 5'($urandom_range(0, 23));
            f.minute  = 6'($urandom_range(0, 59));
            f.second  = 6'($urandom_range(0, 59));
            f.weekday = 3'($urandom_range(1, 7));
        end
        return f;
    endfunction

    initial begin
        int          k;
        logic [63:0] bits;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(MODE_INC, '0);
        send_item(MODE_DEC, '0);
        send_item(MODE_LOAD, '1);
        send_item(MODE_SET, '0);
        send_item(MODE_LOAD, '0);
        send_item(MODE_INC, '0);
        send_item(MODE_DEC, '0);
        send_item(MODE_SET, '0);
        send_item(MODE_DEC, '0);
        send_item(MODE_SET, '0);
        send_item(MODE_INC, '0);
        send_item(MODE_DEC, '0);
        send_item(MODE_SET, '0);
        send_item(MODE_SET, '0);
        send_item(MODE_INC, '0);
        send_item(MODE_SET, '0);
        send_item(MODE_INC, '0);
        send_item(MODE_DEC, '0);
        send_item(MODE_SET, '0);
        send_item(MODE_LOAD, '0);
        send_item(MODE_SET, '1);
        send_item(MODE_SET, '1);
        send_item(MODE_DEC, '1);

        while (items_sent < N_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                bits = {$urandom, $urandom};
                send_item(mode_t'($urandom_range(0, 3)), bits[35:0]);
            end else begin
                send_item(MODE_LOAD, random_date());
                send_item(MODE_SET, random_date());
                for (int p = 0; p < 6; p++) begin
                    k = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
                    repeat (k) begin
                        send_item(($urandom_range(0, 1) == 1) ? MODE_INC : MODE_DEC,
                                  random_date());
                    end
                    send_item(MODE_SET, random_date());
                end
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (pending_count == 0);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
